// ===== hdl/sramp_pkg.sv =====
`timescale 1ns / 1ps

package sramp_pkg;

  localparam int POS_BITS  = 12;
  localparam int TIME_BITS = 32;
  localparam int CH_BITS   = 4;
  localparam int PROD_BITS = POS_BITS + TIME_BITS;
  localparam int CNT_BITS  = $clog2(PROD_BITS);

  localparam logic [POS_BITS-1:0] RESET_POS = POS_BITS'(150);
  localparam logic [CH_BITS-1:0]  RESET_CH  = '0;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_start;
    logic snap;
    logic calc_init;
    logic mul_load;
    logic div_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_tick;
    logic idle;
    logic past;
    logic same;
    logic rem_zero;
    logic mag_small;
  } status_t;

endpackage

// ===== hdl/sramp_if.sv =====
`timescale 1ns / 1ps

interface sramp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [sramp_pkg::TIME_BITS-1:0]     time_now;
  logic [sramp_pkg::TIME_BITS-1:0]     move_duration;
  logic [sramp_pkg::POS_BITS-1:0]      start_pos;
  logic [sramp_pkg::POS_BITS-1:0]      target_pos;

  modport source (
    output valid, req_type, time_now, move_duration, start_pos, target_pos,
    input  ready
  );
  modport sink (
    input  valid, req_type, time_now, move_duration, start_pos, target_pos,
    output ready
  );
endinterface

interface sramp_out_if;
  logic                              valid;
  logic                              ready;
  logic [sramp_pkg::POS_BITS-1:0]    position;
  logic [sramp_pkg::CH_BITS-1:0]     channel;
  logic                              move_done;

  modport source (
    output valid, position, channel, move_done,
    input  ready
  );
  modport sink (
    input  valid, position, channel, move_done,
    output ready
  );
endinterface

// ===== hdl/sramp_ctrl.sv =====
`timescale 1ns / 1ps

module sramp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sramp_pkg::status_t  st_i,
  output sramp_pkg::cmd_t     cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [sramp_pkg::CNT_BITS-1:0] CNT_LAST =
    sramp_pkg::CNT_BITS'(sramp_pkg::PROD_BITS - 1);

  logic [1:0]                       state_q, state_d;
  logic [sramp_pkg::CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                             out_valid_q, out_valid_d;
  logic                             out_free;
  logic                             accept;
  logic                             load_out;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!st_i.req_tick) begin
            cmd_o.load_start = 1'b1;
          end else if (st_i.idle || (!st_i.past && st_i.same)) begin
            // nothing to report
          end else if (st_i.past) begin
            cmd_o.snap = 1'b1;
          end else begin
            cmd_o.calc_init = 1'b1;
            state_d         = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (st_i.rem_zero) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.mul_load = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (st_i.mag_small) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign load_out = cmd_o.load_start || cmd_o.snap || cmd_o.commit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/sramp_dp.sv =====
`timescale 1ns / 1ps

module sramp_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sramp_pkg::cmd_t                     cmd_i,
  output sramp_pkg::status_t                  st_o,
  input  logic                                req_type_i,
  input  logic [sramp_pkg::TIME_BITS-1:0]     time_now_i,
  input  logic [sramp_pkg::TIME_BITS-1:0]     move_duration_i,
  input  logic [sramp_pkg::POS_BITS-1:0]      start_pos_i,
  input  logic [sramp_pkg::POS_BITS-1:0]      target_pos_i,
  input  logic                                cfg_we_i,
  input  logic [sramp_pkg::CH_BITS-1:0]       cfg_data_i,
  output logic [sramp_pkg::POS_BITS-1:0]      position_o,
  output logic [sramp_pkg::CH_BITS-1:0]       channel_o,
  output logic                                move_done_o
);

  localparam int PW = sramp_pkg::POS_BITS;
  localparam int TW = sramp_pkg::TIME_BITS;
  localparam int QW = sramp_pkg::PROD_BITS;

  // move state
  logic [TW-1:0]  deadline_q, deadline_d;
  logic [TW-1:0]  last_q, last_d;
  logic [PW-1:0]  goal_q, goal_d;
  logic [PW-1:0]  cur_q, cur_d;
  logic [sramp_pkg::CH_BITS-1:0] pwm_q;

  // step computation
  logic [TW-1:0]  now_q, elapsed_q, remain_q, rem_q;
  logic [PW-1:0]  dist_q;
  logic           neg_q;
  logic [QW-1:0]  quo_q;

  logic [TW:0]    trial, diff;
  logic           ge;
  logic [PW:0]    mag;
  logic [PW+1:0]  sum_ext, dif_ext;
  logic [PW-1:0]  next_pos;
  logic           mag_over;

  assign st_o.req_tick  = (req_type_i == sramp_pkg::REQ_TICK);
  assign st_o.idle      = (deadline_q == '0);
  assign st_o.past      = (time_now_i >= deadline_q);
  assign st_o.same      = (time_now_i == last_q);
  assign st_o.rem_zero  = (remain_q == '0);
  assign st_o.mag_small = (quo_q[QW-1:1] == '0);

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, quo_q[QW-1]};
  assign diff  = trial - {1'b0, remain_q};
  assign ge    = (trial >= {1'b0, remain_q});

  // magnitude clamped to one full range
  assign mag_over = (|quo_q[QW-1:PW+1]) || (quo_q[PW] && (|quo_q[PW-1:0]));
  assign mag      = mag_over ? {1'b1, {PW{1'b0}}} : quo_q[PW:0];
  assign sum_ext  = {2'b00, cur_q} + {1'b0, mag};
  assign dif_ext  = {2'b00, cur_q} - {1'b0, mag};

  always_comb begin
    if (neg_q) begin
      next_pos = dif_ext[PW+1] ? '0 : dif_ext[PW-1:0];
    end else begin
      next_pos = (|sum_ext[PW+1:PW]) ? '1 : sum_ext[PW-1:0];
    end
  end

  always_comb begin
    deadline_d = deadline_q;
    last_d     = last_q;
    goal_d     = goal_q;
    cur_d      = cur_q;
    if (cmd_i.load_start) begin
      deadline_d = time_now_i + move_duration_i;
      last_d     = time_now_i;
      goal_d     = target_pos_i;
      cur_d      = start_pos_i;
    end else if (cmd_i.snap) begin
      deadline_d = '0;
      last_d     = '0;
      goal_d     = '0;
      cur_d      = goal_q;
    end else if (cmd_i.commit) begin
      last_d = now_q;
      cur_d  = next_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= '0;
      last_q     <= '0;
      goal_q     <= '0;
      cur_q      <= sramp_pkg::RESET_POS;
      pwm_q      <= sramp_pkg::RESET_CH;
    end else begin
      deadline_q <= deadline_d;
      last_q     <= last_d;
      goal_q     <= goal_d;
      cur_q      <= cur_d;
      if (cfg_we_i) begin
        pwm_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_init) begin
      now_q     <= time_now_i;
      elapsed_q <= time_now_i - last_q;
      remain_q  <= deadline_q - last_q;
      neg_q     <= (goal_q < cur_q);
      dist_q    <= (goal_q < cur_q) ? (cur_q - goal_q) : (goal_q - cur_q);
    end
    if (cmd_i.mul_load) begin
      quo_q <= {{TW{1'b0}}, dist_q} * {{PW{1'b0}}, elapsed_q};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[QW-2:0], ge};
      rem_q <= ge ? diff[TW-1:0] : trial[TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      position_o  <= start_pos_i;
      move_done_o <= 1'b0;
      channel_o   <= pwm_q;
    end else if (cmd_i.snap) begin
      position_o  <= goal_q;
      move_done_o <= 1'b1;
      channel_o   <= pwm_q;
    end else if (cmd_i.commit) begin
      position_o  <= next_pos;
      move_done_o <= 1'b0;
      channel_o   <= pwm_q;
    end
  end

endmodule

// ===== hdl/servo_timed_ramp.sv =====
`timescale 1ns / 1ps

// Timed linear servo ramp. A start transaction (req_type 0) loads the move
// and reports start_pos; a tick transaction (req_type 1) snaps to the target
// once time_now reaches the deadline (move_done 1) or steps the position by
// the truncated share (target-pos)*(now-last)/(deadline-last) when that step
// exceeds one count. For a start, a snap and ticks ignored while idle or with
// no time elapsed, the result, if any, sits in the output register the cycle
// after the transaction. A tick with no time left between the last update and
// the deadline reports nothing. A stepping tick latches the time differences,
// forms the 12x32 multiply, runs the bit-serial restoring divider and then
// writes the result, waiting for the output register to be empty or drained;
// a step of one count or less writes nothing. A new transaction is taken
// whenever the sequencer is idle and the output register is empty or being
// drained. pwm_channel is written through cfg_we_i/cfg_data_i; the user must
// do so only while the block is idle; the block does not enforce it.

module servo_timed_ramp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sramp_in_if.sink                         in_if,
  sramp_out_if.source                      out_if,
  input  logic                             cfg_we_i,
  input  logic [sramp_pkg::CH_BITS-1:0]    cfg_data_i
);

  sramp_pkg::cmd_t     cmd;
  sramp_pkg::status_t  st;

  // sequencer: accept, multiply, divide, write back
  sramp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // move state, step arithmetic and output register
  sramp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .req_type_i      (in_if.req_type),
    .time_now_i      (in_if.time_now),
    .move_duration_i (in_if.move_duration),
    .start_pos_i     (in_if.start_pos),
    .target_pos_i    (in_if.target_pos),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .position_o      (out_if.position),
    .channel_o       (out_if.channel),
    .move_done_o     (out_if.move_done)
  );

  // a start transaction shows start_pos in the next cycle
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.req_type == sramp_pkg::REQ_START) |=>
      (out_if.valid && !out_if.move_done && out_if.position == $past(in_if.start_pos)))
    else $error("start transaction did not report start position");

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_start || cmd.snap || cmd.commit) |-> (!out_if.valid || out_if.ready))
    else $error("output register overwritten while pending");

  // completion leaves the block idle
  a_snap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.snap |=> st.idle)
    else $error("block not idle after move completion");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int PHASE_ITEMS    = 250;

  typedef struct packed {
    logic                            req_type;
    logic [sramp_pkg::TIME_BITS-1:0] time_now;
    logic [sramp_pkg::TIME_BITS-1:0] move_duration;
    logic [sramp_pkg::POS_BITS-1:0]  start_pos;
    logic [sramp_pkg::POS_BITS-1:0]  target_pos;
  } ramp_req_t;

  typedef struct packed {
    logic [sramp_pkg::POS_BITS-1:0] position;
    logic [sramp_pkg::CH_BITS-1:0]  channel;
    logic                           move_done;
  } ramp_upd_t;

  typedef struct {
    ramp_req_t                      req;
    bit                             typed;
    bit                             has_upd;
    logic [sramp_pkg::POS_BITS-1:0] pos;
    logic                           done;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [sramp_pkg::CH_BITS-1:0] cfg_data;

  sramp_in_if  req_bus ();
  sramp_out_if upd_bus ();

  servo_timed_ramp u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (req_bus),
    .out_if     (upd_bus),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  // mirror of the ramp state
  logic [sramp_pkg::TIME_BITS-1:0] ramp_deadline;
  logic [sramp_pkg::TIME_BITS-1:0] ramp_last_time;
  logic [sramp_pkg::POS_BITS-1:0]  ramp_goal;
  logic [sramp_pkg::POS_BITS-1:0]  ramp_pos;
  logic [sramp_pkg::CH_BITS-1:0]   ramp_chan;

  ramp_upd_t expected_updates[$];
  dir_row_t  dir_rows[$];
  int        err_cnt;
  int        sent_cnt;
  int        idle_cycles;
  int        ready_hold;
  bit        stall_en;

  initial begin
    clk_i = 1'b0;
  end
  always #4 clk_i = ~clk_i;

  // next position for one accepted transaction
  function automatic void ramp_predict(input ramp_req_t r, output bit has,
                                       output ramp_upd_t upd);
    logic [sramp_pkg::TIME_BITS-1:0] e32;
    logic [sramp_pkg::TIME_BITS-1:0] r32;
    logic [63:0]                     span;
    logic [63:0]                     mag;
    bit                              neg;
    longint                          nxt;
    has = 1'b0;
    upd = '0;
    upd.channel = ramp_chan;
    if (r.req_type == sramp_pkg::REQ_START) begin
      ramp_deadline  = r.time_now + r.move_duration;
      ramp_goal      = r.target_pos;
      ramp_pos       = r.start_pos;
      ramp_last_time = r.time_now;
      upd.position   = ramp_pos;
      has = 1'b1;
      return;
    end
    if (ramp_deadline == '0) return;
    if (r.time_now >= ramp_deadline) begin
      ramp_pos       = ramp_goal;
      upd.position   = ramp_pos;
      upd.move_done  = 1'b1;
      ramp_deadline  = '0;
      ramp_last_time = '0;
      ramp_goal      = '0;
      has = 1'b1;
      return;
    end
    if (r.time_now == ramp_last_time) return;
    e32 = r.time_now - ramp_last_time;
    r32 = ramp_deadline - ramp_last_time;
    if (r32 == '0) return;
    neg  = ramp_goal < ramp_pos;
    span = neg ? 64'(ramp_pos - ramp_goal) : 64'(ramp_goal - ramp_pos);
    mag  = (span * 64'(e32)) / 64'(r32);
    if (mag <= 64'd1) return;
    if (mag > 64'(1 << sramp_pkg::POS_BITS)) mag = 64'(1 << sramp_pkg::POS_BITS);
    nxt = neg ? longint'(ramp_pos) - longint'(mag) : longint'(ramp_pos) + longint'(mag);
    if (nxt < 0) nxt = 0;
    if (nxt > longint'((1 << sramp_pkg::POS_BITS) - 1)) nxt = (1 << sramp_pkg::POS_BITS) - 1;
    ramp_pos       = sramp_pkg::POS_BITS'(nxt);
    ramp_last_time = r.time_now;
    upd.position   = ramp_pos;
    has = 1'b1;
  endfunction

  function automatic ramp_req_t mk_req(input logic kind, input logic [31:0] now,
                                       input logic [31:0] dur,
                                       input logic [sramp_pkg::POS_BITS-1:0] sp,
                                       input logic [sramp_pkg::POS_BITS-1:0] tp);
    ramp_req_t r;
    r.req_type      = kind;
    r.time_now      = now;
    r.move_duration = dur;
    r.start_pos     = sp;
    r.target_pos    = tp;
    return r;
  endfunction

  function automatic logic [sramp_pkg::POS_BITS-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return sramp_pkg::POS_BITS'($urandom_range(0, (1 << sramp_pkg::POS_BITS) - 1));
    endcase
  endfunction

  task automatic add_row(input logic kind, input logic [31:0] now, input logic [31:0] dur,
                         input logic [sramp_pkg::POS_BITS-1:0] sp,
                         input logic [sramp_pkg::POS_BITS-1:0] tp,
                         input bit typed, input bit has,
                         input logic [sramp_pkg::POS_BITS-1:0] pos,
                         input logic done);
    dir_row_t row;
    row.req     = mk_req(kind, now, dur, sp, tp);
    row.typed   = typed;
    row.has_upd = has;
    row.pos     = pos;
    row.done    = done;
    dir_rows.push_back(row);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic drive_item(input ramp_req_t r, input bit typed, input bit t_has,
                            input logic [sramp_pkg::POS_BITS-1:0] t_pos,
                            input logic t_done);
    bit        has;
    ramp_upd_t upd;
    if (stall_en && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    req_bus.valid         <= 1'b1;
    req_bus.req_type      <= r.req_type;
    req_bus.time_now      <= r.time_now;
    req_bus.move_duration <= r.move_duration;
    req_bus.start_pos     <= r.start_pos;
    req_bus.target_pos    <= r.target_pos;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    ramp_predict(r, has, upd);
    sent_cnt++;
    if (typed) begin
      if (t_has) begin
        upd.position  = t_pos;
        upd.channel   = ramp_chan;
        upd.move_done = t_done;
        expected_updates.push_back(upd);
      end
    end else if (has) begin
      expected_updates.push_back(upd);
    end
    @(negedge clk_i);
  endtask

  task automatic drive(input ramp_req_t r);
    drive_item(r, 1'b0, 1'b0, '0, 1'b0);
  endtask

  // wait for all updates, then for a full stepping tick that may emit nothing
  task automatic settle();
    req_bus.valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_channel(input logic [sramp_pkg::CH_BITS-1:0] ch);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= ch;
    @(posedge clk_i);
    ramp_chan = ch;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // one move: start, then mostly rising-time ticks, up to the deadline or a random early stop
  task automatic run_move();
    logic [31:0] base;
    logic [31:0] dur;
    logic [31:0] dl;
    logic [31:0] t;
    logic [31:0] inc_max;
    bit          stop;
    int          sel;
    base = $urandom;
    if ($urandom_range(0, 3) == 0) base = $urandom_range(0, 5000);
    case ($urandom_range(0, 19))
      0:       dur = '0;
      1:       dur = $urandom;
      2, 3:    dur = $urandom_range(1, 20);
      default: dur = $urandom_range(20, 4000);
    endcase
    drive(mk_req(sramp_pkg::REQ_START, base, dur, rand_pos(), rand_pos()));
    dl      = base + dur;
    t       = base;
    stop    = 1'b0;
    inc_max = dur / 6 + 2;
    for (int k = 0; k < 40 && !stop; k++) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        drive(mk_req(sramp_pkg::REQ_TICK, $urandom, $urandom, rand_pos(), rand_pos()));
      end else if (sel == 1) begin
        stop = 1'b1;
      end else begin
        t = t + $urandom_range(0, inc_max);
        drive(mk_req(sramp_pkg::REQ_TICK, t, $urandom, rand_pos(), rand_pos()));
        if (t >= dl) stop = 1'b1;
      end
    end
    if (!stop) drive(mk_req(sramp_pkg::REQ_TICK, dl + $urandom_range(0, 3), '0, '0, '0));
  endtask

  task automatic run_phase(input int n_items);
    int target;
    target = sent_cnt + n_items;
    while (sent_cnt < target) begin
      case ($urandom_range(0, 9))
        7:       drive(mk_req(sramp_pkg::REQ_TICK, $urandom, $urandom, rand_pos(),
                              rand_pos()));
        8:       drive(mk_req(sramp_pkg::REQ_START, $urandom, $urandom, rand_pos(),
                              rand_pos()));
        default: run_move();
      endcase
    end
  endtask

  // update checker
  always @(posedge clk_i) begin : upd_check
    ramp_upd_t e;
    if (rst_ni && upd_bus.valid === 1'b1 && upd_bus.ready === 1'b1) begin
      if (expected_updates.size() == 0) begin
        $display("%0t: unexpected update pos %0d ch %0d done %0b", $time,
                 upd_bus.position, upd_bus.channel, upd_bus.move_done);
        err_cnt++;
      end else begin
        e = expected_updates.pop_front();
        if (upd_bus.position !== e.position) begin
          $display("%0t: position expected %0d actual %0d", $time, e.position,
                   upd_bus.position);
          err_cnt++;
        end
        if (upd_bus.channel !== e.channel) begin
          $display("%0t: channel expected %0d actual %0d", $time, e.channel,
                   upd_bus.channel);
          err_cnt++;
        end
        if (upd_bus.move_done !== e.move_done) begin
          $display("%0t: move_done expected %0b actual %0b", $time, e.move_done,
                   upd_bus.move_done);
          err_cnt++;
        end
      end
    end
  end

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      upd_bus.ready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 10) - 1;
      upd_bus.ready <= 1'b0;
    end else begin
      upd_bus.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (req_bus.valid && req_bus.ready) ||
        (upd_bus.valid && upd_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("servo_timed_ramp regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_data              = '0;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = sramp_pkg::REQ_START;
    req_bus.time_now      = '0;
    req_bus.move_duration = '0;
    req_bus.start_pos     = '0;
    req_bus.target_pos    = '0;
    upd_bus.ready         = 1'b0;
    ramp_deadline         = '0;
    ramp_last_time        = '0;
    ramp_goal             = '0;
    ramp_pos              = sramp_pkg::RESET_POS;
    ramp_chan             = sramp_pkg::RESET_CH;
    err_cnt               = 0;
    sent_cnt              = 0;
    idle_cycles           = 0;
    ready_hold            = 0;
    stall_en              = 1'b1;

    // directed rows, typed where the answer is obvious
    add_row(sramp_pkg::REQ_TICK,  0, 0, 0, 0, 1, 0, 0, 0);              // tick while idle
    add_row(sramp_pkg::REQ_START, 100, 1000, 0, 4095, 1, 1, 0, 0);
    add_row(sramp_pkg::REQ_TICK,  100, 0, 0, 0, 0, 0, 0, 0);            // no time elapsed
    add_row(sramp_pkg::REQ_TICK,  600, 0, 0, 0, 0, 0, 0, 0);
    add_row(sramp_pkg::REQ_TICK,  1100, 0, 0, 0, 1, 1, 4095, 1);        // snap to goal
    add_row(sramp_pkg::REQ_TICK,  2000, 0, 0, 0, 1, 0, 0, 0);
    add_row(sramp_pkg::REQ_START, 32'hFFFF_FFF0, 32'h10, 4095, 0, 1, 1, 4095, 0); // wraps
    add_row(sramp_pkg::REQ_TICK,  5, 0, 0, 0, 1, 0, 0, 0);
    add_row(sramp_pkg::REQ_START, 50, 0, 10, 20, 1, 1, 10, 0);          // zero duration
    add_row(sramp_pkg::REQ_TICK,  0, 0, 0, 0, 1, 0, 0, 0);              // zero remaining time
    add_row(sramp_pkg::REQ_TICK,  50, 0, 0, 0, 1, 1, 20, 1);
    add_row(sramp_pkg::REQ_START, 1000, 1000, 4095, 0, 1, 1, 4095, 0);  // falling ramp
    add_row(sramp_pkg::REQ_TICK,  1001, 0, 0, 0, 0, 0, 0, 0);
    add_row(sramp_pkg::REQ_TICK,  1002, 0, 0, 0, 0, 0, 0, 0);
    add_row(sramp_pkg::REQ_START, 3000, 1000, 100, 101, 1, 1, 100, 0);
    add_row(sramp_pkg::REQ_TICK,  3500, 0, 0, 0, 0, 0, 0, 0);           // step too small
    add_row(sramp_pkg::REQ_START, 1000, 1000, 0, 4095, 1, 1, 0, 0);
    add_row(sramp_pkg::REQ_TICK,  500, 0, 0, 0, 0, 0, 0, 0);  // time backwards, saturates
    add_row(sramp_pkg::REQ_TICK,  32'hFFFF_FFFF, 0, 0, 0, 1, 1, 4095, 1);
    add_row(sramp_pkg::REQ_START, 0, 32'hFFFF_FFFF, 4095, 0, 1, 1, 4095, 0);
    add_row(sramp_pkg::REQ_TICK,  32'hFFFF_FFFE, 0, 0, 0, 0, 0, 0, 0);
    add_row(sramp_pkg::REQ_TICK,  32'hFFFF_FFFF, 0, 0, 0, 1, 1, 0, 1);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      drive_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].has_upd,
                 dir_rows[i].pos, dir_rows[i].done);

    write_channel('1);
    run_phase(PHASE_ITEMS);
    write_channel(sramp_pkg::CH_BITS'($urandom_range(1, 14)));
    run_phase(PHASE_ITEMS);
    write_channel('0);
    run_phase(PHASE_ITEMS);
    write_channel(sramp_pkg::CH_BITS'($urandom));
    run_phase(PHASE_ITEMS);
    // last stretch runs without any idling
    write_channel(sramp_pkg::CH_BITS'($urandom));
    stall_en = 1'b0;
    run_phase(PHASE_ITEMS);

    settle();
    if (err_cnt == 0) begin
      $display("servo_timed_ramp regression: pass");
    end else begin
      $display("servo_timed_ramp regression: fail");
    end
    $finish;
  end

endmodule
